FILE: rtl/core/bfps_pkg.sv
// shared constants and control types for the bit field pack store
package bfps_pkg;

   // fixed field widths
   localparam int VALUE_W = 64;
   localparam int SPAN_W  = 72;
   localparam int INDEX_W = 11;
   localparam int COUNT_W = 7;
   localparam int CAP_W   = 12;
   localparam int CMP_W   = 18;
   localparam int BADDR_W = 9;
   localparam int NREM_W  = 4;
   localparam int SHIFT_W = 7;

   // configuration port
   localparam int PADDR_W = 3;
   localparam int PDATA_W = 32;
   localparam logic REG_CAPACITY = 1'b0;
   localparam logic [CAP_W-1:0] CAP_RESET = 12'd2048;

   // parameter defaults
   localparam int BUF_BYTES_DEF      = 256;
   localparam int MAX_FIELD_BITS_DEF = 64;

   // opcodes and status
   localparam logic OP_WRITE   = 1'b0;
   localparam logic OP_READ    = 1'b1;
   localparam logic STS_DONE   = 1'b0;
   localparam logic STS_REFUSE = 1'b1;

   typedef struct packed {
      logic load;
      logic prep;
      logic rd;
      logic modify;
      logic finish;
      logic init_wr;
   } cmd_type;

   typedef struct packed {
      logic skip;
      logic last_byte;
      logic init_last;
   } sts_type;

endpackage

FILE: rtl/core/bfps_ctrl.sv
// sequencer for the bit field pack store
module bfps_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  bfps_pkg::sts_type sts,
   output bfps_pkg::cmd_type cmd
);

   localparam logic [2:0] ST_INIT = 3'd0;
   localparam logic [2:0] ST_IDLE = 3'd1;
   localparam logic [2:0] ST_LOAD = 3'd2;
   localparam logic [2:0] ST_READ = 3'd3;
   localparam logic [2:0] ST_MOD  = 3'd4;
   localparam logic [2:0] ST_FIN  = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_INIT: begin
            cmd.init_wr = 1'b1;
            if (sts.init_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.prep = 1'b1;
            state_in = sts.skip ? ST_FIN : ST_READ;
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_MOD;
         end
         ST_MOD: begin
            cmd.modify = 1'b1;
            state_in   = sts.last_byte ? ST_FIN : ST_READ;
         end
         ST_FIN: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/core/bfps_datapath.sv
// byte store, field alignment and result registers
module bfps_datapath #(
   parameter int BUF_BYTES      = bfps_pkg::BUF_BYTES_DEF,
   parameter int MAX_FIELD_BITS = bfps_pkg::MAX_FIELD_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  bfps_pkg::cmd_type               cmd,
   output bfps_pkg::sts_type               sts,
   input  logic [bfps_pkg::CAP_W-1:0]      cap_bits,
   input  logic                            req_opcode,
   input  logic [bfps_pkg::INDEX_W-1:0]    req_bit_index,
   input  logic [bfps_pkg::COUNT_W-1:0]    req_bit_count,
   input  logic [bfps_pkg::VALUE_W-1:0]    req_value,
   input  logic                            req_clear_bytes,
   output logic                            rsp_valid,
   output logic [bfps_pkg::VALUE_W-1:0]    rsp_read_value,
   output logic                            rsp_status
);

   localparam int ADDR_W = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;

   logic [7:0] mem [BUF_BYTES];

   // latched item
   logic                           op_ff;
   logic [bfps_pkg::INDEX_W-1:0]   pos_ff;
   logic [bfps_pkg::COUNT_W-1:0]   cnt_ff;
   logic [bfps_pkg::VALUE_W-1:0]   val_ff;
   logic                           clr_ff;

   // working registers
   logic [bfps_pkg::SPAN_W-1:0]    vsh_ff;
   logic [bfps_pkg::SPAN_W-1:0]    msh_ff;
   logic [bfps_pkg::SPAN_W-1:0]    acc_ff;
   logic [bfps_pkg::VALUE_W-1:0]   fmask_ff;
   logic [bfps_pkg::NREM_W-1:0]    nrem_ff;
   logic [bfps_pkg::BADDR_W-1:0]   addr_ff;
   logic [bfps_pkg::SHIFT_W-1:0]   sh_ff;
   logic                           refused_ff;
   logic                           skip_ff;
   logic [7:0]                     rdata_ff;
   logic [ADDR_W-1:0]              init_ff;

   logic                           rsp_valid_ff;
   logic [bfps_pkg::VALUE_W-1:0]   read_value_ff;
   logic                           status_ff;

   // combinational
   logic [bfps_pkg::COUNT_W-1:0]   cnt_sat;
   logic [bfps_pkg::CMP_W-1:0]     end_bytes;
   logic [bfps_pkg::CMP_W-1:0]     cap_round;
   logic [bfps_pkg::CMP_W-1:0]     cap_bytes;
   logic                           zero;
   logic                           refused;
   logic [bfps_pkg::VALUE_W-1:0]   fmask;
   logic [2:0]                     lsb;
   logic [bfps_pkg::NREM_W-1:0]    nbytes;
   logic [bfps_pkg::SHIFT_W-1:0]   sh_next;
   logic                           wr_en;
   logic [ADDR_W-1:0]              wr_addr;
   logic [7:0]                     wr_data;
   logic [bfps_pkg::VALUE_W-1:0]   extracted;

   always_comb begin
      cnt_sat = (cnt_ff > bfps_pkg::COUNT_W'(MAX_FIELD_BITS))
              ? bfps_pkg::COUNT_W'(MAX_FIELD_BITS) : cnt_ff;
      end_bytes = (bfps_pkg::CMP_W'(pos_ff) + bfps_pkg::CMP_W'(cnt_sat)
                + bfps_pkg::CMP_W'(7)) >> 3;
      cap_round = (bfps_pkg::CMP_W'(cap_bits) + bfps_pkg::CMP_W'(7)) >> 3;
      cap_bytes = (cap_round > bfps_pkg::CMP_W'(BUF_BYTES))
                ? bfps_pkg::CMP_W'(BUF_BYTES) : cap_round;
      zero    = (cnt_sat == '0);
      refused = !zero && (end_bytes > cap_bytes);
      fmask   = bfps_pkg::VALUE_W'(~({bfps_pkg::SPAN_W{1'b1}} << cnt_sat));
      lsb     = pos_ff[2:0];
      // bytes spanned: last touched byte relative to the first, plus one
      nbytes  = bfps_pkg::NREM_W'(((bfps_pkg::COUNT_W'(lsb) + cnt_sat
              - bfps_pkg::COUNT_W'(1)) >> 3) + bfps_pkg::COUNT_W'(1));
      // first byte lands at 8*(9-n) in the accumulator, then the bit offset
      sh_next = bfps_pkg::SHIFT_W'({(4'd9 - nbytes), 3'b000})
              + bfps_pkg::SHIFT_W'(lsb);
   end

   assign sts.skip      = zero || refused;
   assign sts.last_byte = (nrem_ff == bfps_pkg::NREM_W'(1));
   assign sts.init_last = (init_ff == ADDR_W'(BUF_BYTES - 1));

   // store write port: clearing pass or read-modify-write of one byte
   always_comb begin
      wr_en   = cmd.init_wr || (cmd.modify && (op_ff == bfps_pkg::OP_WRITE));
      wr_addr = cmd.init_wr ? init_ff : ADDR_W'(addr_ff);
      if (cmd.init_wr) begin
         wr_data = '0;
      end else if (clr_ff) begin
         wr_data = vsh_ff[7:0];
      end else begin
         wr_data = (rdata_ff & ~msh_ff[7:0]) | vsh_ff[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (cmd.rd) rdata_ff <= mem[ADDR_W'(addr_ff)];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff <= '0;
      end else if (cmd.init_wr) begin
         init_ff <= init_ff + ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_opcode;
         pos_ff <= req_bit_index;
         cnt_ff <= req_bit_count;
         val_ff <= req_value;
         clr_ff <= req_clear_bytes;
      end
      if (cmd.prep) begin
         vsh_ff     <= bfps_pkg::SPAN_W'(val_ff & fmask) << lsb;
         msh_ff     <= bfps_pkg::SPAN_W'(fmask) << lsb;
         fmask_ff   <= fmask;
         nrem_ff    <= nbytes;
         addr_ff    <= bfps_pkg::BADDR_W'(pos_ff[bfps_pkg::INDEX_W-1:3]);
         sh_ff      <= sh_next;
         refused_ff <= refused;
         skip_ff    <= zero || refused;
      end
      if (cmd.modify) begin
         vsh_ff  <= vsh_ff >> 8;
         msh_ff  <= msh_ff >> 8;
         acc_ff  <= {rdata_ff, acc_ff[bfps_pkg::SPAN_W-1:8]};
         addr_ff <= addr_ff + bfps_pkg::BADDR_W'(1);
         nrem_ff <= nrem_ff - bfps_pkg::NREM_W'(1);
      end
   end

   assign extracted = bfps_pkg::VALUE_W'(acc_ff >> sh_ff) & fmask_ff;

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         read_value_ff <= ((op_ff == bfps_pkg::OP_READ) && !skip_ff) ? extracted : '0;
         status_ff     <= refused_ff ? bfps_pkg::STS_REFUSE : bfps_pkg::STS_DONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.finish;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = read_value_ff;
   assign rsp_status     = status_ff;

endmodule

FILE: rtl/core/bit_field_pack_store.sv
// top level of the bit field pack store: csr block, sequencer and datapath
// per item: load and check, then a read step and a modify step per byte spanned (1 to 9 bytes), then finish
// zero-width or refused items go from the check straight to finish; the result strobe is registered from finish
// a new item is taken only once the previous one is finished and busy is low
// reset: store is zeroed by a sweep over all BUF_BYTES bytes with busy high; csr writes still taken
// results are strobed for one cycle only, the receiver cannot stall
module bit_field_pack_store #(
   parameter int BUF_BYTES      = bfps_pkg::BUF_BYTES_DEF,
   parameter int MAX_FIELD_BITS = bfps_pkg::MAX_FIELD_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // command channel
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_opcode,
   input  logic [bfps_pkg::INDEX_W-1:0]    req_bit_index,
   input  logic [bfps_pkg::COUNT_W-1:0]    req_bit_count,
   input  logic [bfps_pkg::VALUE_W-1:0]    req_value,
   input  logic                            req_clear_bytes,
   // result channel
   output logic                            rsp_valid,
   output logic [bfps_pkg::VALUE_W-1:0]    rsp_read_value,
   output logic                            rsp_status,
   // csr port
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [bfps_pkg::PADDR_W-1:0]    paddr,
   input  logic [bfps_pkg::PDATA_W-1:0]    pwdata,
   output logic [bfps_pkg::PDATA_W-1:0]    prdata,
   output logic                            pready
);

   bfps_pkg::cmd_type cmd;
   bfps_pkg::sts_type sts;

   logic [bfps_pkg::CAP_W-1:0] cap_ff;
   logic                       csr_sel_cap;
   logic                       csr_wr;

   // csr: one register, capacity in bits, at word 0
   assign pready      = 1'b1;
   assign csr_sel_cap = (paddr[bfps_pkg::PADDR_W-1:2] == bfps_pkg::REG_CAPACITY);
   assign csr_wr      = psel && penable && pwrite && pready;
   assign prdata      = csr_sel_cap ? bfps_pkg::PDATA_W'(cap_ff) : '0;

   // a write transfer to any other word is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= bfps_pkg::CAP_RESET;
      end else if (csr_wr && csr_sel_cap) begin
         cap_ff <= pwdata[bfps_pkg::CAP_W-1:0];
      end
   end

   // sequencer: clear sweep, then per item load, check, per-byte read/modify, finish
   bfps_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   // datapath: byte store, alignment shifters and result registers
   bfps_datapath #(
      .BUF_BYTES      (BUF_BYTES),
      .MAX_FIELD_BITS (MAX_FIELD_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .cap_bits        (cap_ff),
      .req_opcode      (req_opcode),
      .req_bit_index   (req_bit_index),
      .req_bit_count   (req_bit_count),
      .req_value       (req_value),
      .req_clear_bytes (req_clear_bytes),
      .rsp_valid       (rsp_valid),
      .rsp_read_value  (rsp_read_value),
      .rsp_status      (rsp_status)
   );

endmodule

FILE: bench/bit_field_pack_store_tb.sv
// self-checking bench for the bit field pack store: directed and random field accesses
`timescale 1ns / 1ps

module bit_field_pack_store_tb;
   import bfps_pkg::*;

   localparam int STORE_BYTES = BUF_BYTES_DEF;
   localparam int FIELD_MAX   = MAX_FIELD_BITS_DEF;
   localparam int CYCLE_LIMIT = 400000;
   localparam int REPORT_MAX  = 40;
   localparam int PHASE_ITEMS = 105;
   localparam int CAP_RANDOM  = -1;
   // capacity register sits at byte address 4*index, index 1 is not decoded
   localparam logic [PADDR_W-1:0] CAP_ADDR   = PADDR_W'(4 * REG_CAPACITY);
   localparam logic [PADDR_W-1:0] SPARE_ADDR = PADDR_W'(4);

   // one command plus an optional hand-typed expectation
   typedef struct packed {
      logic               op;
      logic [INDEX_W-1:0] bit_index;
      logic [COUNT_W-1:0] bit_count;
      logic [VALUE_W-1:0] value;
      logic               clear;
      logic               typed;
      logic [VALUE_W-1:0] typed_value;
      logic               typed_status;
   } bench_cmd_type;

   typedef struct packed {
      logic [VALUE_W-1:0] read_value;
      logic               status;
   } result_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic               req_opcode;
   logic [INDEX_W-1:0] req_bit_index;
   logic [COUNT_W-1:0] req_bit_count;
   logic [VALUE_W-1:0] req_value;
   logic               req_clear_bytes;
   logic               rsp_valid;
   logic [VALUE_W-1:0] rsp_read_value;
   logic               rsp_status;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [PADDR_W-1:0] paddr;
   logic [PDATA_W-1:0] pwdata;
   logic [PDATA_W-1:0] prdata;
   logic               pready;

   // shadow of the packed store and the capacity register
   logic [7:0]         store_img [STORE_BYTES];
   logic [CAP_W-1:0]   cap_img;
   result_type         pending_results [$];
   int                 mismatch_count;
   int                 cycle_count;
   int                 burst_left;
   logic [INDEX_W-1:0] recent_index;
   logic [COUNT_W-1:0] recent_count;

   bit_field_pack_store dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_bit_index   (req_bit_index),
      .req_bit_count   (req_bit_count),
      .req_value       (req_value),
      .req_clear_bytes (req_clear_bytes),
      .rsp_valid       (rsp_valid),
      .rsp_read_value  (rsp_read_value),
      .rsp_status      (rsp_status),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   // 12 ns clock
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // watchdog, sized far above the slowest legal run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // field access as the block must perform it; updates the shadow store
   function automatic result_type predict_field_access(input bench_cmd_type c);
      result_type r;
      int      n;
      int      pos;
      int      cap_bytes;
      int      b;
      int      p;
      r = '0;
      r.status = STS_DONE;
      n = (int'(c.bit_count) > FIELD_MAX) ? FIELD_MAX : int'(c.bit_count);
      pos = int'(c.bit_index);
      // zero width: nothing touched, never refused
      if (n == 0) return r;
      cap_bytes = (int'(cap_img) + 7) >> 3;
      if (cap_bytes > STORE_BYTES) cap_bytes = STORE_BYTES;
      // end byte past capacity: refused, store untouched
      if (((pos + n + 7) >> 3) > cap_bytes) begin
         r.status = STS_REFUSE;
         return r;
      end
      if (c.op == OP_WRITE) begin
         // clear wipes every touched byte, neighbor bits included
         if (c.clear)
            for (b = pos >> 3; b <= ((pos + n - 1) >> 3); b++) store_img[b] = 8'h00;
         for (int i = 0; i < n; i++) begin
            p = pos + i;
            store_img[p >> 3][p & 7] = c.value[i];
         end
      end else begin
         // clear flag has no effect on reads
         for (int i = 0; i < n; i++) begin
            p = pos + i;
            r.read_value[i] = store_img[p >> 3][p & 7];
         end
      end
      return r;
   endfunction

   function automatic bench_cmd_type make_cmd(input logic op, input int idx, input int cnt,
                                     input logic [VALUE_W-1:0] val, input int clr,
                                     input int typed, input logic [VALUE_W-1:0] exp_val,
                                     input logic exp_sts);
      bench_cmd_type c;
      c.op           = op;
      c.bit_index    = INDEX_W'(idx);
      c.bit_count    = COUNT_W'(cnt);
      c.value        = val;
      c.clear        = 1'(clr);
      c.typed        = 1'(typed);
      c.typed_value  = exp_val;
      c.typed_status = exp_sts;
      return c;
   endfunction

   // random command biased toward the in-capacity region and its upper edge
   function automatic bench_cmd_type random_cmd();
      bench_cmd_type c;
      int   pick;
      int   span;
      int   lo;
      int   hi;
      logic reuse;
      c = '0;
      reuse = 1'b0;
      span = (cap_img > 12'd2048) ? 2048 : int'(cap_img);
      c.op = OP_READ;
      if ($urandom_range(0, 1) == 0) c.op = OP_WRITE;
      pick = $urandom_range(0, 9);
      if (pick < 3 || span == 0) begin
         c.bit_index = INDEX_W'($urandom_range(0, 2047));
      end else if (pick < 6) begin
         c.bit_index = INDEX_W'($urandom_range(0, span - 1));
      end else if (pick < 8) begin
         // straddle the capacity boundary
         lo = (span > 80) ? span - 80 : 0;
         hi = (span + 8 > 2047) ? 2047 : span + 8;
         c.bit_index = INDEX_W'($urandom_range(lo, hi));
      end else begin
         // read back a field written lately
         c.op = OP_READ;
         c.bit_index = recent_index;
         reuse = 1'b1;
      end
      pick = $urandom_range(0, 19);
      if (reuse && pick > 9) c.bit_count = recent_count;
      else if (pick == 0) c.bit_count = '0;
      else if (pick < 3) c.bit_count = COUNT_W'($urandom_range(FIELD_MAX + 1, 127));
      else if (pick < 6) c.bit_count = COUNT_W'(FIELD_MAX);
      else c.bit_count = COUNT_W'($urandom_range(1, FIELD_MAX - 1));
      pick = $urandom_range(0, 9);
      if (pick == 0) c.value = '1;
      else if (pick == 1) c.value = '0;
      else c.value = {$urandom, $urandom};
      c.clear = 1'($urandom_range(0, 1));
      if (c.op == OP_WRITE) begin
         recent_index = c.bit_index;
         recent_count = c.bit_count;
      end
      return c;
   endfunction

   // idle cycles before the next command, with occasional gap-free bursts
   function automatic int draw_gap();
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 9) == 0) burst_left = 20;
      return $urandom_range(0, 6);
   endfunction

   // one command transfer; start stays high across back-to-back commands
   task automatic issue_command(input bench_cmd_type c, input int gap);
      result_type r;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_opcode      <= c.op;
      req_bit_index   <= c.bit_index;
      req_bit_count   <= c.bit_count;
      req_value       <= c.value;
      req_clear_bytes <= c.clear;
      @(posedge clock);
      while (busy) @(posedge clock);
      // accepted at this edge
      r = predict_field_access(c);
      if (c.typed) begin
         r.read_value = c.typed_value;
         r.status     = c.typed_status;
      end
      pending_results.push_back(r);
   endtask

   // drain: every result in and the block idle
   task automatic settle();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic csr_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      // only index 0 is decoded, only its low 12 bits are kept
      if ((addr >> 2) == REG_CAPACITY) cap_img = data[CAP_W-1:0];
      @(posedge clock);
   endtask

   task automatic csr_read(input logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= addr;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      data = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // result checker, sampled at the edge that ends the strobe cycle
   always @(posedge clock) begin
      result_type exp_r;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $error("result strobe with no command outstanding");
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_read_value !== exp_r.read_value) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $error("read_value: expected %h, actual %h", exp_r.read_value,
                         rsp_read_value);
            end
            if (rsp_status !== exp_r.status) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $error("status: expected %0d, actual %0d", exp_r.status, rsp_status);
            end
         end
      end
   end

   // stimulus
   initial begin
      bench_cmd_type      directed [$];
      int                 cap_plan [11];
      int                 cap_val;
      int                 waited;
      logic [PDATA_W-1:0] csr_data;
      logic [VALUE_W-1:0] ones;

      ones            = '1;
      reset           = 1'b1;
      start           = 1'b0;
      req_opcode      = OP_WRITE;
      req_bit_index   = '0;
      req_bit_count   = '0;
      req_value       = '0;
      req_clear_bytes = 1'b0;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      mismatch_count  = 0;
      cycle_count     = 0;
      burst_left      = 0;
      recent_index    = '0;
      recent_count    = COUNT_W'(8);
      cap_img         = CAP_RESET;
      foreach (store_img[k]) store_img[k] = 8'h00;

      // directed part: op, index, count, value, clear, typed, value, status
      // cleared store, reset capacity, top of store edges
      directed.push_back(make_cmd(OP_READ, 0, 64, '0, 0, 1, '0, STS_DONE));
      directed.push_back(make_cmd(OP_READ, 1984, 64, '0, 0, 1, '0, STS_DONE));
      directed.push_back(make_cmd(OP_READ, 1985, 64, '0, 0, 1, '0, STS_REFUSE));
      directed.push_back(make_cmd(OP_WRITE, 2047, 1, ones, 0, 1, '0, STS_DONE));
      directed.push_back(make_cmd(OP_WRITE, 2047, 2, ones, 1, 1, '0, STS_REFUSE));
      // zero width does nothing, clear included
      directed.push_back(make_cmd(OP_WRITE, 0, 0, ones, 1, 1, '0, STS_DONE));
      directed.push_back(make_cmd(OP_READ, 2047, 0, '0, 0, 1, '0, STS_DONE));
      directed.push_back(make_cmd(OP_READ, 2047, 1, '0, 0, 1, 64'd1, STS_DONE));
      directed.push_back(make_cmd(OP_WRITE, 0, 64, ones, 0, 1, '0, STS_DONE));
      directed.push_back(make_cmd(OP_READ, 0, 64, '0, 0, 0, '0, STS_DONE));
      // clear drops neighbor bits of the touched byte
      directed.push_back(make_cmd(OP_WRITE, 3, 5, 64'h1a, 1, 0, '0, STS_DONE));
      directed.push_back(make_cmd(OP_READ, 0, 16, '0, 0, 0, '0, STS_DONE));
      // oversized count saturates to the field maximum
      directed.push_back(make_cmd(OP_WRITE, 13, 127, 64'hdeadbeefcafef00d, 0, 0, '0,
                                  STS_DONE));
      directed.push_back(make_cmd(OP_READ, 13, 100, '0, 0, 0, '0, STS_DONE));
      // clear flag on a read changes nothing
      directed.push_back(make_cmd(OP_READ, 5, 64, '0, 1, 0, '0, STS_DONE));
      directed.push_back(make_cmd(OP_READ, 5, 64, '0, 0, 0, '0, STS_DONE));
      // unaligned nine-byte span
      directed.push_back(make_cmd(OP_WRITE, 1, 64, '0, 1, 0, '0, STS_DONE));
      directed.push_back(make_cmd(OP_READ, 0, 72, '0, 0, 0, '0, STS_DONE));
      directed.push_back(make_cmd(OP_WRITE, 2040, 8, 64'ha5, 0, 0, '0, STS_DONE));
      directed.push_back(make_cmd(OP_READ, 2040, 8, '0, 0, 0, '0, STS_DONE));
      directed.push_back(make_cmd(OP_READ, 2047, 127, '0, 0, 1, '0, STS_REFUSE));
      directed.push_back(make_cmd(OP_WRITE, 1024, 64, 64'h0123456789abcdef, 1, 0, '0,
                                  STS_DONE));
      directed.push_back(make_cmd(OP_WRITE, 1020, 1, 64'd1, 1, 0, '0, STS_DONE));
      directed.push_back(make_cmd(OP_READ, 1020, 64, '0, 0, 0, '0, STS_DONE));

      // capacity settings per random phase: extremes, byte edges, saturation
      cap_plan = '{0, 1, 8, 9, 100, 4095, CAP_RANDOM, 2047, 2049, 512, 2048};

      // reset held first, then the store clearing sweep holds busy
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[k]) issue_command(directed[k], draw_gap());

      // random phases, capacity changed only with the block idle
      foreach (cap_plan[k]) begin
         settle();
         cap_val = (cap_plan[k] == CAP_RANDOM) ? $urandom_range(0, 4095) : cap_plan[k];
         csr_data = $urandom;
         csr_data[CAP_W-1:0] = CAP_W'(cap_val);
         csr_write(CAP_ADDR, csr_data);
         // undecoded index must leave capacity alone
         csr_write(SPARE_ADDR, $urandom);
         csr_read(CAP_ADDR, csr_data);
         if (csr_data !== PDATA_W'(cap_img)) begin
            mismatch_count++;
            $error("capacity_bits: expected %0d, actual %0d", cap_img, csr_data);
         end
         repeat (PHASE_ITEMS) issue_command(random_cmd(), draw_gap());
      end

      // wind down: wait out every result, then watch for stray strobes
      start <= 1'b0;
      for (waited = 0; waited < 4000 && pending_results.size() != 0; waited++)
         @(posedge clock);
      repeat (40) @(posedge clock);
      if (pending_results.size() != 0) begin
         mismatch_count++;
         $error("%0d results never arrived", pending_results.size());
      end

      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
